>>> sv/ile_pkg.sv
package ile_pkg;
    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W = 32;
    localparam int OP_W = 4;
    localparam int IDX_W = 8;
    localparam int ST_W = 2;

    localparam logic [OP_W-1:0] OP_APPEND  = 4'd0;
    localparam logic [OP_W-1:0] OP_RMTAIL  = 4'd1;
    localparam logic [OP_W-1:0] OP_POP     = 4'd2;
    localparam logic [OP_W-1:0] OP_RMAT    = 4'd3;
    localparam logic [OP_W-1:0] OP_GETAT   = 4'd4;
    localparam logic [OP_W-1:0] OP_INSAT   = 4'd5;
    localparam logic [OP_W-1:0] OP_CLEAR   = 4'd6;
    localparam logic [OP_W-1:0] OP_REVERSE = 4'd7;
    localparam logic [OP_W-1:0] OP_ROTATE  = 4'd8;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_INDEX = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

    // Shift commands broadcast to every cell of the chain.
    typedef struct packed {
        logic load;      // cell lo takes the new word, cells lo+1..hi take their left neighbor
        logic shl;       // cells lo..hi-1 take their right neighbor, cell hi takes the wrap word
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } t_shift;
endpackage

>>> sv/indexed_list_engine.sv
// Indexed list engine: an ordered list of up to CAPACITY signed words.
// Requests arrive on the input channel (i_valid/o_ready) as one word of
// operation, value and index; each request yields exactly one result word
// on the output channel (o_valid/i_ready) with status, read value and length.
// The list lives in a chain of CAPACITY cells, cell 0 holding position 1.
// Every cell can take its left or right neighbor at the same edge, so edits
// move the whole tail at once inside a window given by two bounds.
// Append, pop, get, insert, remove, clear and bad requests are done at the
// accepting edge, and their result is valid in the next cycle.
// Reverse does window rotations with a shrinking window, each moving the
// tail word to the window's low end, then a closing step. Rotate first
// reduces the amount modulo count by repeated subtraction, then rotates
// the list right by amount mod count in single steps, then a closing
// step. The longest request is a rotate of a one-element list by 255.
// One request is in flight at a time: o_ready is high only while no
// request is being worked and the result register is empty or being taken.
// A stalled receiver simply holds the result; no new request is taken.
// Reset clears the element count and the handshake state; cell contents
// are left alone, since a cell is only read below the count.
module indexed_list_engine #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [ile_pkg::OP_W-1:0]           i_operation,
    input  logic signed [ile_pkg::DATA_W-1:0]  i_value,
    input  logic [ile_pkg::IDX_W-1:0]          i_index,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [ile_pkg::ST_W-1:0]           o_status,
    output logic signed [ile_pkg::DATA_W-1:0]  o_read_value,
    output logic [ile_pkg::IDX_W-1:0]          o_length
);
    localparam int DW = ile_pkg::DATA_W;
    localparam int IW = ile_pkg::IDX_W;
    localparam int AW = $clog2(CAPACITY);
    localparam int SW = 2;
    localparam logic [IW-1:0] CAP = IW'(CAPACITY);
    localparam logic [SW-1:0] S_IDLE = 2'd0;
    localparam logic [SW-1:0] S_MOD  = 2'd1;
    localparam logic [SW-1:0] S_ROT  = 2'd2;
    localparam logic [SW-1:0] S_REV  = 2'd3;

    logic [SW-1:0] r_state, n_state;
    logic [IW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_k, n_k;      // remaining rotate steps / reverse window low
    logic          r_ovalid, n_ovalid;
    logic [ile_pkg::ST_W-1:0] r_st, n_st;
    logic [DW-1:0] r_rd, n_rd;
    ile_pkg::t_shift cmd;
    logic [DW-1:0] new_data;
    logic [DW-1:0] cells [CAPACITY];

    // Chain of cells; rotations feed the tail word back in through i_new.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ile_cell #(.POS(g)) u_cell (
            .i_clk  (i_clk),
            .i_cmd  (cmd),
            .i_left ((g == 0) ? cells[0] : cells[(g == 0) ? 0 : g-1]),
            .i_right((g == CAPACITY-1) ? cells[g] : cells[(g == CAPACITY-1) ? g : g+1]),
            .i_wrap (cells[g]),
            .i_new  (new_data),
            .o_data (cells[g])
        );
    end

    wire take = i_valid && o_ready;
    wire out_free = !r_ovalid || i_ready;
    assign o_ready = (r_state == S_IDLE) && out_free;
    wire [IW-1:0] idx = i_index;
    wire idx_ok = (idx != '0) && (idx <= r_cnt);
    wire [AW-1:0] tail_addr = AW'(r_cnt - 1'b1);
    wire [AW-1:0] get_addr = AW'(idx - 1'b1);

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_k = r_k;
        n_ovalid = r_ovalid && !i_ready; n_st = r_st; n_rd = r_rd;
        cmd = '0; new_data = i_value;
        unique case (r_state)
            S_IDLE: if (take) begin
                n_ovalid = 1'b1; n_st = ile_pkg::ST_OK; n_rd = '0;
                unique case (i_operation)
                    ile_pkg::OP_APPEND: begin
                        if (r_cnt >= CAP) n_st = ile_pkg::ST_FULL;
                        else begin
                            cmd.load = 1'b1; cmd.lo = r_cnt; cmd.hi = r_cnt;
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                    ile_pkg::OP_RMTAIL, ile_pkg::OP_POP: begin
                        if (r_cnt == '0) n_st = ile_pkg::ST_EMPTY;
                        else begin
                            if (i_operation == ile_pkg::OP_POP)
                                n_rd = cells[tail_addr];
                            n_cnt = r_cnt - 1'b1;
                        end
                    end
                    ile_pkg::OP_RMAT: begin
                        if (r_cnt == '0) n_st = ile_pkg::ST_EMPTY;
                        else if (!idx_ok) n_st = ile_pkg::ST_INDEX;
                        else begin
                            cmd.shl = 1'b1; cmd.lo = idx - 1'b1; cmd.hi = CAP;
                            n_cnt = r_cnt - 1'b1;
                        end
                    end
                    ile_pkg::OP_GETAT: begin
                        if (r_cnt == '0) n_st = ile_pkg::ST_EMPTY;
                        else if (!idx_ok) n_st = ile_pkg::ST_INDEX;
                        else n_rd = cells[get_addr];
                    end
                    ile_pkg::OP_INSAT: begin
                        if (r_cnt == '0) begin
                            if (idx != 8'd1) n_st = ile_pkg::ST_EMPTY;
                            else begin
                                cmd.load = 1'b1; n_cnt = 8'd1;
                            end
                        end else if (r_cnt >= CAP) n_st = ile_pkg::ST_FULL;
                        else if (!idx_ok) n_st = ile_pkg::ST_INDEX;
                        else begin
                            cmd.load = 1'b1; cmd.lo = idx - 1'b1; cmd.hi = r_cnt;
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                    ile_pkg::OP_CLEAR: n_cnt = '0;
                    ile_pkg::OP_REVERSE: begin
                        if (r_cnt == '0) n_st = ile_pkg::ST_EMPTY;
                        else begin
                            n_ovalid = 1'b0; n_k = '0; n_state = S_REV;
                        end
                    end
                    ile_pkg::OP_ROTATE: begin
                        if (r_cnt == '0) n_st = ile_pkg::ST_EMPTY;
                        else begin
                            n_ovalid = 1'b0; n_k = idx; n_state = S_MOD;
                        end
                    end
                    default: ;
                endcase
            end
            S_MOD: begin
                if (r_k >= r_cnt) n_k = r_k - r_cnt;
                else n_state = S_ROT;
            end
            S_ROT: begin
                // One rotate-right step: the tail word enters at cell 0.
                if (r_k == '0) begin
                    n_state = S_IDLE; n_ovalid = 1'b1;
                end else begin
                    cmd.load = 1'b1; cmd.lo = '0; cmd.hi = r_cnt - 1'b1;
                    new_data = cells[tail_addr];
                    n_k = r_k - 1'b1;
                end
            end
            S_REV: begin
                // move the last element to cell r_k, shifting the rest up
                if (r_k + 1'b1 >= r_cnt) begin
                    n_state = S_IDLE; n_ovalid = 1'b1;
                end else begin
                    cmd.load = 1'b1; cmd.lo = r_k; cmd.hi = r_cnt - 1'b1;
                    new_data = cells[tail_addr];
                    n_k = r_k + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= '0; r_ovalid <= 1'b0; r_k <= '0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_ovalid <= n_ovalid; r_k <= n_k;
        end
        r_st <= n_st; r_rd <= n_rd;
    end

    assign o_valid = r_ovalid;
    assign o_status = r_st;
    assign o_read_value = r_rd;
    assign o_length = r_cnt;

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP) else $error("count above capacity");
    a_busy_noready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_busy_noout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_ovalid) else $error("result during work");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> (r_ovalid && $stable(r_rd) && $stable(r_st)))
        else $error("result dropped");
endmodule

>>> sv/ile_cell.sv
module ile_cell #(
    parameter int POS = 0
) (
    input  logic                        i_clk,
    input  ile_pkg::t_shift             i_cmd,
    input  logic [ile_pkg::DATA_W-1:0]  i_left,
    input  logic [ile_pkg::DATA_W-1:0]  i_right,
    input  logic [ile_pkg::DATA_W-1:0]  i_wrap,
    input  logic [ile_pkg::DATA_W-1:0]  i_new,
    output logic [ile_pkg::DATA_W-1:0]  o_data
);
    localparam logic [ile_pkg::IDX_W-1:0] P = ile_pkg::IDX_W'(POS);
    logic [ile_pkg::DATA_W-1:0] r_data;
    logic [ile_pkg::DATA_W-1:0] n_data;

    // lo and hi define a window; the cell at lo takes i_new in load mode.
    always_comb begin
        priority if (i_cmd.load && P == i_cmd.lo) begin
            n_data = i_new;
        end else if (i_cmd.load && P > i_cmd.lo && P <= i_cmd.hi) begin
            n_data = i_left;
        end else if (i_cmd.shl && P >= i_cmd.lo && P < i_cmd.hi) begin
            n_data = i_right;
        end else if (i_cmd.shl && P == i_cmd.hi) begin
            n_data = i_wrap;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end
    assign o_data = r_data;
endmodule

>>> test/indexed_list_engine_tb.sv
module indexed_list_engine_tb;
    localparam int CAP = ile_pkg::CAPACITY_DEF;
    localparam int DATA_W = ile_pkg::DATA_W;
    localparam int OP_W = ile_pkg::OP_W;
    localparam int IDX_W = ile_pkg::IDX_W;
    localparam int ST_W = ile_pkg::ST_W;
    // Operation codes with no function; they must leave the list alone.
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd9;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;
    // Longest quiet stretch is a long receiver stall plus a worst-case request.
    localparam int QUIET_LIMIT = 20000;
    localparam int RANDOM_WORDS = 1350;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         index;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] read_value;
        logic [IDX_W-1:0]         length;
    } t_rsp;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic [OP_W-1:0]          i_operation;
    logic signed [DATA_W-1:0] i_value;
    logic [IDX_W-1:0]         i_index;
    logic                     o_valid;
    logic                     i_ready;
    logic [ST_W-1:0]          o_status;
    logic signed [DATA_W-1:0] o_read_value;
    logic [IDX_W-1:0]         o_length;

    indexed_list_engine i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_operation(i_operation), .i_value(i_value), .i_index(i_index),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_read_value(o_read_value), .o_length(o_length)
    );

    // Shadow copy of the list contents and the element count.
    logic signed [DATA_W-1:0] shadow_list [CAP];
    int                       shadow_count = 0;

    t_req pending_words [$];
    t_rsp expected_results [$];
    int   error_count = 0;
    int   quiet_cycles = 0;
    bit   stimulus_done = 1'b0;

    // Whether the word on the input was taken at the last rising edge.
    logic o_ready_seen;

    always #4 i_clk = ~i_clk;

    // Apply one request to the shadow list and return the result it causes.
    function automatic t_rsp apply_request(t_req r);
        logic signed [DATA_W-1:0] moved [CAP];
        logic signed [DATA_W-1:0] tmp;
        t_rsp res;
        int n;
        int k;
        n = shadow_count;
        res.status = ile_pkg::ST_OK;
        res.read_value = '0;
        case (r.operation)
            ile_pkg::OP_APPEND: begin
                if (n >= CAP) res.status = ile_pkg::ST_FULL;
                else begin
                    shadow_list[n] = r.value;
                    shadow_count = n + 1;
                end
            end
            ile_pkg::OP_RMTAIL, ile_pkg::OP_POP: begin
                if (n == 0) res.status = ile_pkg::ST_EMPTY;
                else begin
                    if (r.operation == ile_pkg::OP_POP) res.read_value = shadow_list[n-1];
                    shadow_count = n - 1;
                end
            end
            ile_pkg::OP_RMAT: begin
                if (n == 0) res.status = ile_pkg::ST_EMPTY;
                else if (r.index < 1 || r.index > n) res.status = ile_pkg::ST_INDEX;
                else begin
                    for (int i = r.index - 1; i + 1 < n; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_count = n - 1;
                end
            end
            ile_pkg::OP_GETAT: begin
                if (n == 0) res.status = ile_pkg::ST_EMPTY;
                else if (r.index < 1 || r.index > n) res.status = ile_pkg::ST_INDEX;
                else res.read_value = shadow_list[r.index-1];
            end
            ile_pkg::OP_INSAT: begin
                if (n == 0) begin
                    if (r.index != 1) res.status = ile_pkg::ST_EMPTY;
                    else begin
                        shadow_list[0] = r.value;
                        shadow_count = 1;
                    end
                end else if (n >= CAP) res.status = ile_pkg::ST_FULL;
                else if (r.index < 1 || r.index > n) res.status = ile_pkg::ST_INDEX;
                else begin
                    for (int i = n; i > r.index - 1; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[r.index-1] = r.value;
                    shadow_count = n + 1;
                end
            end
            ile_pkg::OP_CLEAR: shadow_count = 0;
            ile_pkg::OP_REVERSE: begin
                if (n == 0) res.status = ile_pkg::ST_EMPTY;
                else begin
                    for (int i = 0; i < n / 2; i++) begin
                        tmp = shadow_list[i];
                        shadow_list[i] = shadow_list[n-1-i];
                        shadow_list[n-1-i] = tmp;
                    end
                end
            end
            ile_pkg::OP_ROTATE: begin
                if (n == 0) res.status = ile_pkg::ST_EMPTY;
                else begin
                    k = r.index % n;
                    for (int i = 0; i < n; i++) moved[(i + k) % n] = shadow_list[i];
                    for (int i = 0; i < n; i++) shadow_list[i] = moved[i];
                end
            end
            default: ;
        endcase
        res.length = shadow_count[IDX_W-1:0];
        return res;
    endfunction

    function automatic t_req make_word(int op, logic [31:0] val, int idx);
        t_req r;
        r.operation = op[OP_W-1:0];
        r.value = val;
        r.index = idx[IDX_W-1:0];
        return r;
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Short gaps mostly, now and then a long one.
    function automatic int random_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Build the stimulus. The random part biases the op mix by phase so the
    // list wanders between empty, half full and full.
    initial begin
        int op;
        int idx;
        int fill_bias;
        int depth;
        pending_words.push_back(make_word(ile_pkg::OP_POP, 0, 0));
        pending_words.push_back(make_word(ile_pkg::OP_RMTAIL, 0, 0));
        pending_words.push_back(make_word(ile_pkg::OP_RMAT, 0, 1));
        pending_words.push_back(make_word(ile_pkg::OP_GETAT, 0, 1));
        pending_words.push_back(make_word(ile_pkg::OP_REVERSE, 0, 0));
        pending_words.push_back(make_word(ile_pkg::OP_ROTATE, 0, 3));
        pending_words.push_back(make_word(ile_pkg::OP_INSAT, 32'h1234, 2));
        pending_words.push_back(make_word(ile_pkg::OP_INSAT, 32'h8000_0000, 1));
        pending_words.push_back(make_word(ile_pkg::OP_REVERSE, 0, 0));
        pending_words.push_back(make_word(ile_pkg::OP_APPEND, 32'h7FFF_FFFF, 0));
        pending_words.push_back(make_word(ile_pkg::OP_APPEND, 32'hFFFF_FFFF, 0));
        pending_words.push_back(make_word(ile_pkg::OP_GETAT, 0, 0));
        pending_words.push_back(make_word(ile_pkg::OP_GETAT, 0, 4));
        pending_words.push_back(make_word(ile_pkg::OP_GETAT, 0, 3));
        pending_words.push_back(make_word(ile_pkg::OP_INSAT, 32'h55, 0));
        pending_words.push_back(make_word(ile_pkg::OP_INSAT, 32'h55, 4));
        pending_words.push_back(make_word(ile_pkg::OP_INSAT, 32'h55, 3));
        pending_words.push_back(make_word(ile_pkg::OP_ROTATE, 0, 255));
        pending_words.push_back(make_word(ile_pkg::OP_REVERSE, 0, 0));
        pending_words.push_back(make_word(ile_pkg::OP_RMAT, 0, 255));
        pending_words.push_back(make_word(ile_pkg::OP_RMAT, 0, 2));
        pending_words.push_back(make_word(OP_UNUSED_LO, 32'hFFFF_FFFF, 255));
        pending_words.push_back(make_word(OP_UNUSED_HI, 0, 0));
        pending_words.push_back(make_word(ile_pkg::OP_CLEAR, 0, 0));
        pending_words.push_back(make_word(ile_pkg::OP_CLEAR, 0, 0));
        // Fill to capacity so the full status is reached, then probe it.
        for (int i = 0; i < CAP + 1; i++)
            pending_words.push_back(make_word(ile_pkg::OP_APPEND, $urandom, 0));
        pending_words.push_back(make_word(ile_pkg::OP_INSAT, 32'h1, 1));
        pending_words.push_back(make_word(ile_pkg::OP_INSAT, 32'h1, 0));
        pending_words.push_back(make_word(ile_pkg::OP_GETAT, 0, CAP));
        pending_words.push_back(make_word(ile_pkg::OP_ROTATE, 0, CAP - 1));
        pending_words.push_back(make_word(ile_pkg::OP_REVERSE, 0, 0));
        pending_words.push_back(make_word(ile_pkg::OP_RMAT, 0, CAP));
        pending_words.push_back(make_word(ile_pkg::OP_RMAT, 0, 1));
        fill_bias = 70;
        depth = CAP - 1;
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 150 == 0) fill_bias = $urandom_range(20, 90);
            op = $urandom_range(0, 99);
            if (op < fill_bias / 2) op = ile_pkg::OP_APPEND;
            else if (op < fill_bias) op = ile_pkg::OP_INSAT;
            else if (op < 97) op = $urandom_range(ile_pkg::OP_RMTAIL, ile_pkg::OP_ROTATE);
            else op = $urandom_range(ile_pkg::OP_CLEAR, OP_UNUSED_HI);
            if (op == ile_pkg::OP_APPEND || op == ile_pkg::OP_INSAT) depth++;
            else if (op == ile_pkg::OP_CLEAR) depth = 0;
            else if (op <= ile_pkg::OP_RMAT) depth--;
            if (depth < 1) depth = 1;
            if (depth > CAP) depth = CAP;
            // Mostly indices inside the list; a few out of range or anywhere.
            case ($urandom_range(0, 9))
                0: idx = $urandom_range(0, 255);
                1: idx = 0;
                2: idx = depth + 1;
                default: idx = $urandom_range(1, depth);
            endcase
            pending_words.push_back(make_word(op, random_value(), idx));
        end
        pending_words.push_back(make_word(ile_pkg::OP_ROTATE, 0, 8'hAA));
        pending_words.push_back(make_word(ile_pkg::OP_INSAT, 32'h0, 8'h55));
    end

    // Driver: offers words at the falling edge, holding each until taken.
    int send_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_operation <= '0;
            i_value <= '0;
            i_index <= '0;
            send_gap = 0;
        end else if (i_valid && !o_ready_seen) begin
            // Held until accepted.
        end else if (send_gap > 0) begin
            send_gap--;
            i_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
            t_req w;
            w = pending_words.pop_front();
            i_valid <= 1'b1;
            i_operation <= w.operation;
            i_value <= w.value;
            i_index <= w.index;
            send_gap = random_gap();
        end else begin
            i_valid <= 1'b0;
            stimulus_done = 1'b1;
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up.
    int  stall_gap;
    int  hold_off;
    bit  hold_done = 1'b0;
    int  taken_words = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_gap = 0;
            hold_off = 0;
        end else if (hold_off > 0) begin
            hold_off--;
            i_ready <= 1'b0;
        end else if (!hold_done && taken_words == 200) begin
            hold_done = 1'b1;
            hold_off = 300;
            i_ready <= 1'b0;
        end else if (stall_gap > 0) begin
            stall_gap--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            stall_gap = random_gap();
        end
    end

    // Monitor: predicts on each accepted word and checks each result.
    always @(posedge i_clk) begin
        t_rsp want;
        logic seen_next;
        int   quiet_next;
        int   taken_next;
        seen_next = 1'b0;
        quiet_next = quiet_cycles;
        taken_next = taken_words;
        if (i_rst_n) begin
            quiet_next = quiet_cycles + 1;
            if (i_valid && o_ready) begin
                seen_next = 1'b1;
                quiet_next = 0;
                taken_next = taken_words + 1;
                expected_results.push_back(apply_request({i_operation, i_value, i_index}));
            end
            if (o_valid && i_ready) begin
                quiet_next = 0;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result status=%0d value=%0d length=%0d",
                             $time, o_status, o_read_value, o_length);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_status);
                        error_count++;
                    end
                    if (o_read_value !== want.read_value) begin
                        $display("%0t: read_value expected %0d actual %0d",
                                 $time, want.read_value, o_read_value);
                        error_count++;
                    end
                    if (o_length !== want.length) begin
                        $display("%0t: length expected %0d actual %0d",
                                 $time, want.length, o_length);
                        error_count++;
                    end
                end
            end
        end
        o_ready_seen <= seen_next;
        quiet_cycles <= quiet_next;
        taken_words <= taken_next;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (!(stimulus_done && expected_results.size() == 0)
               && quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("indexed_list_engine: mismatch");
        end else begin
            // Give the block time to show any stray result.
            repeat (300) @(posedge i_clk);
            if (error_count == 0) begin
                $display("indexed_list_engine: match");
            end else begin
                $display("indexed_list_engine: mismatch");
            end
        end
        $finish;
    end
endmodule

>>> indexed_list_engine.f
sv/ile_pkg.sv
sv/ile_cell.sv
sv/indexed_list_engine.sv
test/indexed_list_engine_tb.sv
